// ===== hw/rtl/pol_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pol_pkg
// Shared types and codes for the positional ordered list unit.
// ----------------------------------------------------------------------------
package pol_pkg;

  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_END   = 3'd1,
    ACT_INS_POS   = 3'd2,
    ACT_DEL_FRONT = 3'd3,
    ACT_DEL_END   = 3'd4,
    ACT_DEL_POS   = 3'd5,
    ACT_SEARCH    = 3'd6
  } pol_act_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_INVALID  = 3'd2;
  localparam logic [2:0] ST_FOUND    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] item_value;
    logic signed [15:0] position;
  } pol_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] found_position;
    logic [6:0] element_count;
  } pol_res_t;

endpackage

// ===== hw/rtl/pol_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pol_mem
// Simple dual-port entry store: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module pol_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/pol_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pol_seq
// Request sequencer: decodes a request, walks the entry store to shift or
// search, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module pol_seq #(
  parameter int CAPACITY = 64,
  parameter int AW       = 6,
  parameter int CW       = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  pol_pkg::pol_req_t req,
  output logic              res_valid,
  input  logic              res_ready,
  output pol_pkg::pol_res_t res,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [31:0]       mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  input  logic [31:0]       mem_rdata
);
  import pol_pkg::*;

  localparam int SW = (CW + 1 > 17) ? CW + 1 : 17;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SHUP = 5'b00010,
    S_SHDN = 5'b00100,
    S_SRCH = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [31:0]    val_r, val_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [AW-1:0]  ptr_r, ptr_nxt;
  logic [CW-1:0]  n_r, n_nxt;
  logic           vld_r, vld_nxt;
  logic [AW-1:0]  vaddr_r, vaddr_nxt;
  logic [2:0]     status_r, status_nxt;
  logic [6:0]     found_r, found_nxt;

  logic signed [SW-1:0] p1;
  logic signed [SW-1:0] cnt_s;
  logic [AW-1:0]        ins_idx;
  logic [AW-1:0]        del_idx;
  logic [AW:0]          hit_pos;

  // position decode: insert lands in [1, count], delete in [0, count-1]
  always_comb begin
    p1    = SW'(req.position) - SW'(1);
    cnt_s = SW'(count_r);
    if (p1 < 1) begin
      ins_idx = AW'(1);
    end else if (p1 > cnt_s) begin
      ins_idx = AW'(count_r);
    end else begin
      ins_idx = AW'(p1);
    end
    if (p1 < 0) begin
      del_idx = '0;
    end else if (p1 > cnt_s - SW'(1)) begin
      del_idx = AW'(count_r - CW'(1));
    end else begin
      del_idx = AW'(p1);
    end
  end

  assign hit_pos = {1'b0, vaddr_r} + (AW + 1)'(1);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    val_nxt    = val_r;
    idx_nxt    = idx_r;
    ptr_nxt    = ptr_r;
    n_nxt      = n_r;
    vld_nxt    = vld_r;
    vaddr_nxt  = vaddr_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    mem_we     = 1'b0;
    mem_waddr  = vaddr_r;
    mem_wdata  = mem_rdata;
    mem_re     = 1'b0;
    mem_raddr  = ptr_r;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          val_nxt    = req.item_value;
          vld_nxt    = 1'b0;
          status_nxt = ST_OK;
          found_nxt  = '0;
          state_nxt  = S_RESP;
          unique case (req.action)
            ACT_INS_FRONT, ACT_INS_END, ACT_INS_POS: begin
              if (count_r == CW'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else begin
                if (req.action == ACT_INS_FRONT) begin
                  idx_nxt = '0;
                end else if (req.action == ACT_INS_END) begin
                  idx_nxt = AW'(count_r);
                end else if (count_r == '0 || req.position == 16'sd1) begin
                  idx_nxt = '0;
                end else begin
                  idx_nxt = ins_idx;
                end
                ptr_nxt   = AW'(count_r - CW'(1));
                n_nxt     = count_r - CW'(idx_nxt);
                state_nxt = S_SHUP;
              end
            end
            ACT_DEL_FRONT, ACT_DEL_END, ACT_DEL_POS: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                if (req.action == ACT_DEL_FRONT ||
                    (req.action == ACT_DEL_POS && req.position == 16'sd1)) begin
                  idx_nxt = '0;
                end else if (req.action == ACT_DEL_END) begin
                  idx_nxt = AW'(count_r - CW'(1));
                end else begin
                  idx_nxt = del_idx;
                end
                if (req.action == ACT_DEL_POS && req.position != 16'sd1 &&
                    del_idx == '0) begin
                  status_nxt = ST_INVALID;
                end else begin
                  ptr_nxt   = idx_nxt + AW'(1);
                  n_nxt     = count_r - CW'(1) - CW'(idx_nxt);
                  state_nxt = S_SHDN;
                end
              end
            end
            ACT_SEARCH: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                status_nxt = ST_NOTFOUND;
                ptr_nxt    = '0;
                n_nxt      = count_r;
                state_nxt  = S_SRCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SHUP: begin
        // move the entry read last cycle one place toward the end
        if (vld_r) begin
          mem_we    = 1'b1;
          mem_waddr = vaddr_r + AW'(1);
        end
        if (n_r != '0) begin
          mem_re    = 1'b1;
          vaddr_nxt = ptr_r;
          ptr_nxt   = ptr_r - AW'(1);
          n_nxt     = n_r - CW'(1);
          vld_nxt   = 1'b1;
        end else begin
          vld_nxt = 1'b0;
          if (!vld_r) begin
            mem_we    = 1'b1;
            mem_waddr = idx_r;
            mem_wdata = val_r;
            count_nxt = count_r + CW'(1);
            state_nxt = S_RESP;
          end
        end
      end
      S_SHDN: begin
        // move the entry read last cycle one place toward the front
        if (vld_r) begin
          mem_we    = 1'b1;
          mem_waddr = vaddr_r - AW'(1);
        end
        if (n_r != '0) begin
          mem_re    = 1'b1;
          vaddr_nxt = ptr_r;
          ptr_nxt   = ptr_r + AW'(1);
          n_nxt     = n_r - CW'(1);
          vld_nxt   = 1'b1;
        end else begin
          vld_nxt = 1'b0;
          if (!vld_r) begin
            count_nxt = count_r - CW'(1);
            state_nxt = S_RESP;
          end
        end
      end
      S_SRCH: begin
        if (vld_r && mem_rdata == val_r) begin
          status_nxt = ST_FOUND;
          found_nxt  = 7'(hit_pos);
          vld_nxt    = 1'b0;
          state_nxt  = S_RESP;
        end else if (n_r != '0) begin
          mem_re    = 1'b1;
          vaddr_nxt = ptr_r;
          ptr_nxt   = ptr_r + AW'(1);
          n_nxt     = n_r - CW'(1);
          vld_nxt   = 1'b1;
        end else begin
          vld_nxt = 1'b0;
          if (!vld_r) begin
            state_nxt = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    ptr_r    <= ptr_nxt;
    n_r      <= n_nxt;
    vaddr_r  <= vaddr_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
  end

  assign req_ready          = (state_r == S_IDLE);
  assign res_valid          = (state_r == S_RESP);
  assign res.status         = status_r;
  assign res.found_position = found_r;
  assign res.element_count  = 7'(count_r);

endmodule

// ===== hw/rtl/positional_ordered_list_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_ordered_list_unit
// Bounded ordered list of signed 32-bit values held in one entry store;
// insert, delete and search requests walk the store one entry a cycle.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)                         | width
//  in_     | in  | action[2:0] item_value[34:3] position[50:35] pad  | 56
//  out_    | out | status[2:0] found_position[9:3] element_count[16:10] | 24
//
//  One request at a time. An insert or a delete shifts the entries from its
//  position to the end of the list, and a search reads entries until a
//  match or the end; every walk is paced by the single read and write port
//  of the entry store, and the result is then held in the sequencer until
//  it is taken.
//  Reset clears the element count and the control state only; entries are
//  read only after they are written, so the store gets no clearing pass.
//  A stalled out_ side holds the result in the output register; the next
//  request is taken while it waits.
// ----------------------------------------------------------------------------
module positional_ordered_list_unit #(
  parameter int CAPACITY = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // action[2:0], item_value[34:3], position[50:35], zero pad [55:51]
  input  logic [pol_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // status[2:0], found_position[9:3], element_count[16:10], zero pad [23:17]
  output logic [pol_pkg::OUT_DATA_W-1:0] out_tdata
);
  import pol_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  pol_req_t      req;
  pol_res_t      res;
  logic          res_valid;
  logic          res_ready;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  logic     out_valid_r;
  pol_res_t out_res_r;

  // unpack the request
  assign req.action     = in_tdata[2:0];
  assign req.item_value = in_tdata[34:3];
  assign req.position   = in_tdata[50:35];

  pol_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  pol_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .WIDTH (32)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.element_count, out_res_r.found_position,
                       out_res_r.status};

endmodule

// ===== hw/rtl/pol_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pol_chk
// Port-level checks for the positional ordered list unit, bound to the top.
// ----------------------------------------------------------------------------
module pol_chk #(
  parameter int CAPACITY = 64
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [pol_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [pol_pkg::OUT_DATA_W-1:0] out_tdata
);
  import pol_pkg::*;

  logic unused_in;
  assign unused_in = ^in_tdata;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one request at a time: an accepted request drops ready
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in work");

  // a found position is reported exactly on a match
  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[2:0] == ST_FOUND) == (out_tdata[9:3] != 7'd0)))
    else $error("found position disagrees with status");

  // an empty status leaves an empty list
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == ST_EMPTY |-> out_tdata[16:10] == 7'd0)
    else $error("empty status with elements present");

  // the count never passes the capacity
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && CAPACITY < 128 |-> 32'(out_tdata[16:10]) <= 32'(CAPACITY))
    else $error("element count above capacity");

endmodule

bind positional_ordered_list_unit pol_chk #(.CAPACITY(CAPACITY)) u_pol_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
